/* rtl/lras_pkg.sv */
// shared constants and controller/datapath interface types for the range add / range sum block
`timescale 1ns / 1ps

package lras_pkg;

    // default element count
    localparam int unsigned SIZE_DEF   = 1024;
    // field widths
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned SUM_W      = 64;
    localparam int unsigned IN_TDATA_W = 56;

    // item kind
    typedef enum logic [0:0] {
        MODE_ADD = 1'b0,
        MODE_SUM = 1'b1
    } mode_t;

    // which of the two tree walks of an item is running
    typedef enum logic [0:0] {
        WALK_FIRST  = 1'b0,
        WALK_SECOND = 1'b1
    } walk_t;

    // controller to datapath commands
    typedef struct packed {
        logic  clr_step;
        logic  load;
        logic  walk_init;
        walk_t walk;
        logic  mem_rd;
        logic  mem_wr;
        logic  acc;
        logic  mul_lo;
        logic  mul_hi;
        logic  fin;
        logic  out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic  clr_done;
        logic  empty;
        mode_t mode;
        logic  walk_done;
        logic  out_free;
    } dp_stat_t;

endpackage

/* rtl/lras_dp.sv */
// datapath: two fenwick trees in two memories, walk index, multipliers and output register
`timescale 1ns / 1ps

module lras_dp
    import lras_pkg::*;
#(
    parameter int unsigned SIZE = SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [SUM_W-1:0]      m_tdata
);

    // address width covers tree nodes 1..SIZE, position width also holds the
    // step past the top of the tree (up to twice SIZE)
    localparam int unsigned AW = $clog2(SIZE + 2);
    localparam int unsigned PW = ((AW > IDX_W + 1) ? AW : IDX_W + 1) + 1;

    // memories: slope tree and offset tree
    logic [SUM_W-1:0] coef_mem [0:SIZE];
    logic [SUM_W-1:0] corr_mem [0:SIZE];

    logic                    mode_reg;
    logic [IDX_W-1:0]        a_reg;
    logic [IDX_W-1:0]        bc_reg;
    logic signed [VAL_W-1:0] v_reg;
    logic [PW-1:0]           idx_reg;
    logic [PW-1:0]           idx_next;
    logic [PW-1:0]           p_reg;
    logic [SUM_W-1:0]        d2_reg;
    logic [SUM_W-1:0]        s1_reg;
    logic [SUM_W-1:0]        s2_reg;
    logic [SUM_W-1:0]        rd1_reg;
    logic [SUM_W-1:0]        rd2_reg;
    logic [SUM_W-1:0]        prod_lo_reg;
    logic [SUM_W-1:0]        prod_hi_reg;
    logic [SUM_W-1:0]        res_reg;
    logic [SUM_W-1:0]        out_data_reg;
    logic                    out_valid_reg;
    logic [AW-1:0]           clr_addr_reg;

    logic [IDX_W-1:0]        b_in;
    logic [IDX_W-1:0]        bc_next;
    logic [PW-1:0]           a_p;
    logic [PW-1:0]           b1_p;
    logic [PW-1:0]           b2_p;
    logic [PW-1:0]           init_idx;
    logic [PW-1:0]           mul_op;
    logic [PW-1:0]           lowbit;
    logic [AW-1:0]           addr;
    logic signed [PW:0]      mul_op_s;
    logic signed [PW+VAL_W:0] upd_prod;
    logic [SUM_W-1:0]        v_ext;
    logic [SUM_W-1:0]        wr1;
    logic [SUM_W-1:0]        wr2;
    logic [VAL_W+PW-1:0]     mlo;
    logic [VAL_W+PW-1:0]     mhi;
    logic [SUM_W-1:0]        prefix;

    // input word unpack and clipping of the high index
    assign b_in    = s_tdata[2*IDX_W:IDX_W+1];
    assign bc_next = (PW'(b_in) > PW'(SIZE - 1)) ? IDX_W'(SIZE - 1) : b_in;

    // walk start points (one-based tree positions)
    assign a_p  = PW'(a_reg);
    assign b1_p = PW'(bc_reg) + PW'(1);
    assign b2_p = PW'(bc_reg) + PW'(2);

    always_comb
    begin
        if (mode_reg == MODE_ADD)
        begin
            init_idx = (cmd.walk == WALK_FIRST) ? a_p + PW'(1) : b2_p;
            mul_op   = (cmd.walk == WALK_FIRST) ? a_p : b1_p;
        end
        else
        begin
            init_idx = (cmd.walk == WALK_FIRST) ? b1_p : a_p;
            mul_op   = init_idx;
        end
    end

    // update weight v * (pos - 1) for the offset tree
    assign mul_op_s = $signed({1'b0, mul_op});
    assign upd_prod = v_reg * mul_op_s;

    // lowest set bit steps the walk up (add) or down (sum)
    assign lowbit   = idx_reg & (~idx_reg + PW'(1));
    assign idx_next = (mode_reg == MODE_ADD) ? idx_reg + lowbit : idx_reg - lowbit;
    assign addr     = idx_reg[AW-1:0];

    // read-modify-write values, second walk subtracts
    assign v_ext = SUM_W'(v_reg);
    assign wr1   = (cmd.walk == WALK_FIRST) ? rd1_reg + v_ext  : rd1_reg - v_ext;
    assign wr2   = (cmd.walk == WALK_FIRST) ? rd2_reg + d2_reg : rd2_reg - d2_reg;

    // prefix = s1 * p - s2, with the 64-bit product split in two halves
    assign mlo    = s1_reg[31:0] * p_reg;
    assign mhi    = s1_reg[63:32] * p_reg;
    assign prefix = prod_lo_reg + (prod_hi_reg << 32) - s2_reg;

    // memory port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            coef_mem[clr_addr_reg] <= '0;
            corr_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            coef_mem[addr] <= wr1;
            corr_mem[addr] <= wr2;
        end
        if (cmd.mem_rd)
        begin
            rd1_reg <= coef_mem[addr];
            rd2_reg <= corr_mem[addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= s_tdata[0];
            a_reg    <= s_tdata[IDX_W:1];
            bc_reg   <= bc_next;
            v_reg    <= s_tdata[2*IDX_W+VAL_W:2*IDX_W+1];
            res_reg  <= '0;
        end
        if (cmd.walk_init)
        begin
            idx_reg <= init_idx;
            p_reg   <= mul_op;
            d2_reg  <= SUM_W'(upd_prod);
            s1_reg  <= '0;
            s2_reg  <= '0;
        end
        if (cmd.mem_wr || cmd.acc)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.acc)
        begin
            s1_reg <= s1_reg + rd1_reg;
            s2_reg <= s2_reg + rd2_reg;
        end
        if (cmd.mul_lo)
        begin
            prod_lo_reg <= SUM_W'(mlo);
        end
        if (cmd.mul_hi)
        begin
            prod_hi_reg <= SUM_W'(mhi);
        end
        if (cmd.fin)
        begin
            res_reg <= (cmd.walk == WALK_FIRST) ? prefix : res_reg - prefix;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // clear sweep counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status back to the controller
    assign stat.clr_done  = (clr_addr_reg == AW'(SIZE));
    assign stat.empty     = (a_reg > bc_reg);
    assign stat.mode      = mode_t'(mode_reg);
    assign stat.walk_done = (mode_reg == MODE_ADD) ? (idx_reg > PW'(SIZE)) : (idx_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/lras_ctrl.sv */
// controller: sequences the clear sweep, the two tree walks and the result hand-off
`timescale 1ns / 1ps

module lras_ctrl
    import lras_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_IDLE   = 12'b0000_0000_0010,
        ST_START  = 12'b0000_0000_0100,
        ST_INIT   = 12'b0000_0000_1000,
        ST_CHECK  = 12'b0000_0001_0000,
        ST_RD     = 12'b0000_0010_0000,
        ST_WR     = 12'b0000_0100_0000,
        ST_ACC    = 12'b0000_1000_0000,
        ST_MUL_LO = 12'b0001_0000_0000,
        ST_MUL_HI = 12'b0010_0000_0000,
        ST_FIN    = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    walk_t  walk_reg;
    walk_t  walk_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        cmd        = '0;
        cmd.walk   = walk_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    walk_next  = WALK_FIRST;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!stat.empty)
                begin
                    state_next = ST_INIT;
                end
                else if (stat.mode == MODE_SUM)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!stat.walk_done)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = (stat.mode == MODE_ADD) ? ST_WR : ST_ACC;
                end
                else if (stat.mode == MODE_SUM)
                begin
                    state_next = ST_MUL_LO;
                end
                else if (walk_reg == WALK_FIRST)
                begin
                    walk_next  = WALK_SECOND;
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHECK;
            end
            ST_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_CHECK;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (walk_reg == WALK_FIRST)
                begin
                    walk_next  = WALK_SECOND;
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            walk_reg  <= WALK_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    // checks
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> $past(cmd.mem_rd))
        else $error("tree write without a read the cycle before");

    a_acc_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> $past(cmd.mem_rd))
        else $error("accumulate without a read the cycle before");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken word");

    a_no_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !s_tready && !cmd.mem_wr)
        else $error("item activity during the clear sweep");

endmodule

/* rtl/lazy_range_add_range_sum.sv */
// range add / range sum store: a non-empty add runs two tree walks with a memory read and a write per node;
// a non-empty sum runs two tree walks with a memory read and an accumulate per node, then the multiply steps;
// a walk visits up to log2(SIZE)+1 nodes, and the block handles one item at a time.
// after reset the tree memory (nodes 0 to SIZE) is swept to zero while no word is taken.
`timescale 1ns / 1ps

module lazy_range_add_range_sum
    import lras_pkg::*;
#(
    parameter int unsigned SIZE = SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // mode [0], range_low [10:1], range_high [20:11], add_value [52:21], zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // range_sum [63:0]
    output logic [SUM_W-1:0]      m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    lras_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // tree memory and arithmetic
    lras_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

/* dv/testbench.sv */
// self-checking testbench for the range add / range sum block
`timescale 1ns / 1ps

// expected query sums, kept from a flat copy of the element array
class range_sum_board;
    longint unsigned elem[1024];
    longint unsigned sums_due[2048];
    int              due_wr;
    int              due_rd;
    int              errors;

    function new();
        foreach (elem[i])
        begin
            elem[i] = 0;
        end
        due_wr = 0;
        due_rd = 0;
        errors = 0;
    endfunction

    // sums still owed by the block
    function int pending();
        return due_wr - due_rd;
    endfunction

    // print one mismatch line and count it
    task report(string what, longint unsigned got, longint unsigned want);
        errors++;
        $display("mismatch: %s got %0h want %0h", what, got, want);
    endtask

    // apply an accepted word to the element copy, queue a sum for queries
    function void note_word(bit is_sum, int unsigned lo, int unsigned hi, int add_val);
        longint unsigned total;
        longint unsigned wide_val;
        total = 0;
        wide_val = longint'(add_val);
        for (int unsigned i = lo; i <= hi && i < 1024; i++)
        begin
            if (is_sum)
                total += elem[i];
            else
                elem[i] += wide_val;
        end
        if (is_sum)
        begin
            sums_due[due_wr % 2048] = total;
            due_wr++;
        end
    endfunction

    // compare one returned sum with the oldest one due
    task check_sum(longint unsigned got);
        longint unsigned want;
        if (pending() == 0)
        begin
            report("unexpected range_sum", got, 0);
            return;
        end
        want = sums_due[due_rd % 2048];
        due_rd++;
        if (want != got)
            report("range_sum", got, want);
    endtask
endclass

module testbench;
    import lras_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SUM_W-1:0]      m_tdata;

    range_sum_board board;
    int  send_idle;
    int  recv_idle;
    bit  hold_off;
    int  cycles;

    lazy_range_add_range_sum dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // check each accepted sum and note each accepted word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_sum(m_tdata);
        if (rst_n && s_tvalid && s_tready)
            board.note_word(s_tdata[0] == MODE_SUM, s_tdata[10:1], s_tdata[20:11],
                            int'(s_tdata[52:21]));
    end

    // receiver ready, with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 900000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // offer one word and wait for it to be taken; valid stays up for the next word
    task automatic send_word(mode_t m, bit [9:0] lo, bit [9:0] hi, bit [31:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, val, hi, lo, m};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random word: mostly short ranges, some wide and empty ones
    task automatic send_random();
        bit [9:0]  lo;
        bit [9:0]  hi;
        bit [31:0] val;
        int        pick;
        pick = $urandom_range(99);
        lo   = 10'($urandom);
        if (pick < 60)
            hi = (lo > 10'd1000) ? 10'd1023 : 10'(lo + $urandom_range(20));
        else if (pick < 90)
            hi = 10'($urandom);
        else
            hi = (lo == 10'd0) ? 10'd0 : lo - 10'd1;
        val = $urandom;
        send_word(mode_t'($urandom_range(1)), lo, hi, val);
    endtask

    initial
    begin
        board     = new();
        cycles    = 0;
        hold_off  = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, empty ranges, wrap-around
        send_word(MODE_SUM, 10'd0, 10'd1023, 32'd0);
        send_word(MODE_ADD, 10'd0, 10'd1023, 32'h7fffffff);
        send_word(MODE_SUM, 10'd0, 10'd1023, 32'd0);
        send_word(MODE_ADD, 10'd0, 10'd1023, 32'h80000000);
        send_word(MODE_SUM, 10'd0, 10'd1023, 32'hffffffff);
        send_word(MODE_ADD, 10'd1023, 10'd1023, 32'hffffffff);
        send_word(MODE_SUM, 10'd1023, 10'd1023, 32'd0);
        send_word(MODE_ADD, 10'd0, 10'd0, 32'h12345678);
        send_word(MODE_SUM, 10'd0, 10'd0, 32'd0);
        send_word(MODE_ADD, 10'd500, 10'd20, 32'h55555555);
        send_word(MODE_SUM, 10'd500, 10'd20, 32'd0);
        send_word(MODE_SUM, 10'd1023, 10'd0, 32'd0);
        send_word(MODE_ADD, 10'd3, 10'd700, 32'haaaaaaaa);
        send_word(MODE_SUM, 10'd2, 10'd701, 32'd0);
        send_word(MODE_SUM, 10'd511, 10'd512, 32'd0);
        for (int i = 0; i < 40; i++)
            send_word(MODE_ADD, 10'd0, 10'd1023, 32'h7fffffff);
        send_word(MODE_SUM, 10'd0, 10'd1023, 32'd0);

        // long receiver hold-off while queries keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_word(MODE_SUM, 10'(i), 10'(1023 - i), 32'd0);
        join

        // random phases with changing idle rates
        send_idle = 17;
        recv_idle = 48;
        repeat (450) send_random();
        send_idle = 48;
        recv_idle = 17;
        repeat (450) send_random();
        send_idle = 0;
        recv_idle = 0;
        repeat (450) send_random();
        s_tvalid <= 1'b0;

        // drain
        while (board.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* lazy_range_add_range_sum.f */
rtl/lras_pkg.sv
rtl/lras_dp.sv
rtl/lras_ctrl.sv
rtl/lazy_range_add_range_sum.sv
dv/testbench.sv
